FILE: rtl/wpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpsm_pkg: shared types and constants of the wheel pulse speed meter
// Item structs, configuration register indexes, widths of ring and divider.
// ----------------------------------------------------------------------------
package wpsm_pkg;

    // Ring of recent pulse intervals; depth is a power of two, at least 2,
    // so the mean is a plain right shift of the running sum.
    localparam int RING_DEPTH = 8;
    localparam int SLOT_W     = $clog2(RING_DEPTH);

    // Field widths
    localparam int TIME_W     = 32;
    localparam int MEAN_W     = 32;
    localparam int DEB_W      = 8;
    localparam int STALL_W    = 16;
    localparam int CIRC_W     = 20;
    localparam int SUM_W      = TIME_W + SLOT_W;

    // Serial divider: one quotient bit per cycle over the circumference width
    localparam int DIV_W      = CIRC_W;
    localparam int CNT_W      = $clog2(DIV_W);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CIRC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 8'd5;
    localparam logic [STALL_W-1:0] STALL_RST    = 16'd1000;
    localparam logic [CIRC_W-1:0]  CIRC_RST     = 20'd50265;

    // Item modes
    localparam logic MODE_PULSE = 1'b0;
    localparam logic MODE_POLL  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_interval_ms;
        logic [CIRC_W-1:0] speed_mm_per_s;
        logic              pulse_accepted;
        logic              timed_out;
    } out_item_t;

endpackage

FILE: rtl/wheel_pulse_speed_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_pulse_speed_meter_core: pulse-period moving-average tachometer
// Debounces wheel pulses, keeps a ring of recent intervals with a running
// sum, clears the ring on a stall poll, and reports mean interval and speed.
// ----------------------------------------------------------------------------
// Steps: from input acceptance to result valid come 3 update steps,
//   1 divider setup, DIV_W = 20 serial divide steps, 1 handoff, plus output wait.
// Flow: one item at a time; the serial circumference/mean divider takes
//   most of each item's time. Not ready while an item is in flight.
// Reset: synchronous, active low; clears ring, sum, slot, last pulse time
//   and restores configuration defaults. No clearing pass is needed.

module wheel_pulse_speed_meter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wpsm_pkg::in_item_t                  s_data,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output wpsm_pkg::out_item_t                 m_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wpsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUB,
        ST_ADD,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [wpsm_pkg::DEB_W-1:0]   debounce_reg;
    logic [wpsm_pkg::STALL_W-1:0] stall_reg;
    logic [wpsm_pkg::CIRC_W-1:0]  circ_reg;

    // tachometer state
    logic [wpsm_pkg::TIME_W-1:0]  last_pulse_reg;
    logic [wpsm_pkg::TIME_W-1:0]  ring_reg [wpsm_pkg::RING_DEPTH];
    logic [wpsm_pkg::SLOT_W-1:0]  slot_reg;
    logic [wpsm_pkg::SUM_W-1:0]   sum_reg;

    // per-item working registers
    wpsm_pkg::in_item_t           item_reg;
    logic [wpsm_pkg::TIME_W-1:0]  elapsed_reg;
    logic                         acc_reg;
    logic                         stalled_reg;
    logic [wpsm_pkg::MEAN_W-1:0]  mean_reg;

    // divider
    logic [wpsm_pkg::DIV_W-1:0]   dvd_reg;
    logic [wpsm_pkg::DIV_W-1:0]   rem_reg;
    logic [wpsm_pkg::DIV_W-1:0]   quo_reg;
    logic [wpsm_pkg::CNT_W-1:0]   cnt_reg;

    // output register
    logic                         m_valid_reg;
    wpsm_pkg::out_item_t          m_data_reg;

    logic [wpsm_pkg::TIME_W-1:0]  elapsed;
    logic [wpsm_pkg::SLOT_W-1:0]  slot_inc;
    logic [wpsm_pkg::DIV_W:0]     trial;
    logic                         fits;
    logic [wpsm_pkg::DIV_W-1:0]   rem_next;
    logic                         out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // interval since last accepted pulse, modulo 2^32
    assign elapsed = item_reg.time_ms - last_pulse_reg;

    // write slot advance with wrap
    assign slot_inc = (slot_reg == wpsm_pkg::SLOT_W'(wpsm_pkg::RING_DEPTH - 1))
                    ? '0 : slot_reg + 1'b1;

    // restoring divide step: circumference / mean
    always_comb begin
        trial    = {rem_reg, dvd_reg[wpsm_pkg::DIV_W-1]};
        fits     = wpsm_pkg::MEAN_W'(trial) >= mean_reg;
        rem_next = fits ? wpsm_pkg::DIV_W'(trial - mean_reg[wpsm_pkg::DIV_W:0])
                        : trial[wpsm_pkg::DIV_W-1:0];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            debounce_reg   <= wpsm_pkg::DEBOUNCE_RST;
            stall_reg      <= wpsm_pkg::STALL_RST;
            circ_reg       <= wpsm_pkg::CIRC_RST;
            last_pulse_reg <= '0;
            for (int i = 0; i < wpsm_pkg::RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            slot_reg       <= '0;
            sum_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // configuration writes; unknown indexes are dropped
            if (cfg_valid) begin
                unique case (cfg_index)
                    wpsm_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wdata[wpsm_pkg::DEB_W-1:0];
                    wpsm_pkg::CFG_STALL:    stall_reg    <= cfg_wdata[wpsm_pkg::STALL_W-1:0];
                    wpsm_pkg::CFG_CIRC:     circ_reg     <= cfg_wdata;
                    default: ;
                endcase
            end

            // result taken downstream; in ST_DONE the handoff decides
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= ST_EVAL;
                    end
                end
                // debounce and stall checks
                ST_EVAL: begin
                    elapsed_reg <= elapsed;
                    acc_reg     <= (item_reg.mode == wpsm_pkg::MODE_PULSE) &&
                                   (elapsed > wpsm_pkg::TIME_W'(debounce_reg));
                    stalled_reg <= (item_reg.mode == wpsm_pkg::MODE_POLL) &&
                                   (elapsed > wpsm_pkg::TIME_W'(stall_reg));
                    state_reg   <= ST_SUB;
                end
                // drop the old entry from the sum, or clear on stall
                ST_SUB: begin
                    if (acc_reg) begin
                        sum_reg <= sum_reg - wpsm_pkg::SUM_W'(ring_reg[slot_reg]);
                    end else if (stalled_reg) begin
                        for (int i = 0; i < wpsm_pkg::RING_DEPTH; i++) begin
                            ring_reg[i] <= '0;
                        end
                        sum_reg  <= '0;
                        slot_reg <= slot_inc;
                    end
                    state_reg <= ST_ADD;
                end
                // store the new interval
                ST_ADD: begin
                    if (acc_reg) begin
                        sum_reg            <= sum_reg + wpsm_pkg::SUM_W'(elapsed_reg);
                        ring_reg[slot_reg] <= elapsed_reg;
                        slot_reg           <= slot_inc;
                        last_pulse_reg     <= item_reg.time_ms;
                    end
                    state_reg <= ST_PREP;
                end
                // mean by shift, load divider
                ST_PREP: begin
                    mean_reg  <= sum_reg[wpsm_pkg::SUM_W-1:wpsm_pkg::SLOT_W];
                    dvd_reg   <= circ_reg;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                // one quotient bit per cycle
                ST_DIV: begin
                    rem_reg <= rem_next;
                    dvd_reg <= {dvd_reg[wpsm_pkg::DIV_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[wpsm_pkg::DIV_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == wpsm_pkg::CNT_W'(wpsm_pkg::DIV_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                // hand the result to the output register
                ST_DONE: begin
                    if (out_free) begin
                        m_data_reg.mean_interval_ms <= mean_reg;
                        m_data_reg.speed_mm_per_s   <= (mean_reg == '0) ? '0 : quo_reg;
                        m_data_reg.pulse_accepted   <= acc_reg;
                        m_data_reg.timed_out        <= stalled_reg;
                        m_valid_reg                 <= 1'b1;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
